// ===== hdl/gel_pkg.sv =====
package gel_pkg;

  localparam int ALLELE_BITS = 8;
  localparam int FRAC_BITS   = 16;
  localparam int PROB_W      = FRAC_BITS + 1;
  localparam int CASE_W      = 3;
  localparam int COUNT_W     = 9;
  localparam int DROP_W      = FRAC_BITS - 1;
  localparam int MIS_W       = FRAC_BITS;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 4 * ALLELE_BITS;
  localparam int OUT_DATA_W  = ((PROB_W + CASE_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - PROB_W - CASE_W;
  localparam int SQ_W        = 2 * PROB_W;
  localparam int PROD_W      = SQ_W + PROB_W;
  localparam int WIDE_W      = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ALLELE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROPOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISTYPE = 2'd2;

  localparam logic [COUNT_W-1:0] RST_ALLELE  = 9'd2;
  localparam logic [DROP_W-1:0]  RST_DROPOUT = 15'd3277;
  localparam logic [MIS_W-1:0]   RST_MISTYPE = 16'd3277;

  localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Match cases.
  localparam logic [CASE_W-1:0] MC_HOM_MATCH = 3'd0;
  localparam logic [CASE_W-1:0] MC_HOM_ONE   = 3'd1;
  localparam logic [CASE_W-1:0] MC_HOM_NONE  = 3'd2;
  localparam logic [CASE_W-1:0] MC_HET_MATCH = 3'd3;
  localparam logic [CASE_W-1:0] MC_HET_DROP  = 3'd4;
  localparam logic [CASE_W-1:0] MC_HET_NONE  = 3'd5;
  localparam logic [CASE_W-1:0] MC_HET_ONE   = 3'd6;
  localparam logic [CASE_W-1:0] MC_SINGLE    = 3'd7;

  typedef struct packed {
    logic [CASE_W-1:0] mcase;
    logic              ohom;
  } item_t;

  typedef struct packed {
    logic ready;
    logic single;
  } cfg_stat_t;

  typedef struct packed {
    logic [PROB_W-1:0] p_hom_match;
    logic [PROB_W-1:0] p_hom_one;
    logic [PROB_W-1:0] p_none_hom;
    logic [PROB_W-1:0] p_none_het;
    logic [PROB_W-1:0] p_het_match;
    logic [PROB_W-1:0] p_het_drop;
    logic [PROB_W-1:0] p_het_one;
  } prob_table_t;

  function automatic logic [PROB_W-1:0] sat_prob(input logic [WIDE_W-1:0] v);
    logic [PROB_W-1:0] r;
    if (v > WIDE_W'(PROB_ONE)) r = PROB_ONE;
    else r = v[PROB_W-1:0];
    return r;
  endfunction

endpackage

// ===== hdl/gel_param.sv =====
module gel_param import gel_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_stat_t             stat,
  output prob_table_t           prob_tab
);

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_DIV    = 6'b000010,
    S_DERIVE = 6'b000100,
    S_MUL    = 6'b001000,
    S_TABLE  = 6'b010000,
    S_READY  = 6'b100000
  } state_t;

  localparam logic [3:0] STEP_SQ_OM   = 4'd0;
  localparam logic [3:0] STEP_SQ_E2   = 4'd1;
  localparam logic [3:0] STEP_SQ_OMM  = 4'd2;
  localparam logic [3:0] STEP_E1_OMM  = 4'd3;
  localparam logic [3:0] STEP_E2_OM   = 4'd4;
  localparam logic [3:0] STEP_E2_OMP  = 4'd5;
  localparam logic [3:0] DIV_LAST     = 4'(MIS_W - 1);

  state_t state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] allele_r;
  logic [DROP_W-1:0]  drop_r;
  logic [MIS_W-1:0]   mis_r;
  logic               restart;

  // Divider: quotient shifts in while the dividend shifts out.
  logic [MIS_W-1:0]   quo_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] div_r;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_sub;
  logic               fits;

  logic [MIS_W-1:0]  e2_r;
  logic [PROB_W-1:0] om_r, omm_r, omp_r;
  logic [PROB_W-1:0] sum_e, om_c, omm_c, omp_c;

  logic [SQ_W-1:0]   mul_a;
  logic [PROB_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [SQ_W-1:0]   sq_om_r, sq_omm_r;
  logic [2*MIS_W-1:0] sq_e2_r;
  logic [PROD_W-1:0] e1_sq_omm_r;
  logic [SQ_W-1:0]   e2_om_r, e2_omp_r;

  logic [WIDE_W-1:0] pos3, neg3, sum4;
  prob_table_t       tab_c, tab_r;

  always_comb begin
    restart = cfg_we && (cfg_index inside {REG_ALLELE, REG_DROPOUT, REG_MISTYPE});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allele_r <= RST_ALLELE;
      drop_r   <= RST_DROPOUT;
      mis_r    <= RST_MISTYPE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALLELE:  allele_r <= cfg_data[COUNT_W-1:0];
        REG_DROPOUT: drop_r   <= cfg_data[DROP_W-1:0];
        REG_MISTYPE: mis_r    <= cfg_data[MIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_LOAD: begin
        state_nxt = S_DIV;
        cnt_nxt   = DIV_LAST;
      end
      S_DIV: begin
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) state_nxt = S_DERIVE;
      end
      S_DERIVE: begin
        state_nxt = S_MUL;
        cnt_nxt   = STEP_SQ_OM;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == STEP_E2_OMP) state_nxt = S_TABLE;
      end
      S_TABLE: state_nxt = S_READY;
      S_READY: ;
      default: state_nxt = S_LOAD;
    endcase
    if (restart) state_nxt = S_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[MIS_W-1]};
    fits    = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        quo_r <= mis_r;
        rem_r <= '0;
        div_r <= allele_r - COUNT_W'(1);
      end
      S_DIV: begin
        quo_r <= {quo_r[MIS_W-2:0], fits};
        rem_r <= fits ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      end
      default: ;
    endcase
  end

  // The total mistyping rate is below one, so 1-E2 and 1-E2+e2 never go negative.
  always_comb begin
    sum_e = {1'b0, mis_r} + {1'b0, quo_r};
    om_c  = PROB_ONE - {1'b0, mis_r};
    omm_c = (sum_e >= PROB_ONE) ? (sum_e - PROB_ONE) : (PROB_ONE - sum_e);
    omp_c = PROB_ONE + {1'b0, quo_r} - {1'b0, mis_r};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DERIVE) begin
      e2_r  <= quo_r;
      om_r  <= om_c;
      omm_r <= omm_c;
      omp_r <= omp_c;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt_r)
      STEP_SQ_OM: begin
        mul_a = SQ_W'(om_r);
        mul_b = om_r;
      end
      STEP_SQ_E2: begin
        mul_a = SQ_W'(e2_r);
        mul_b = PROB_W'(e2_r);
      end
      STEP_SQ_OMM: begin
        mul_a = SQ_W'(omm_r);
        mul_b = omm_r;
      end
      STEP_E1_OMM: begin
        mul_a = sq_omm_r;
        mul_b = PROB_W'(drop_r);
      end
      STEP_E2_OM: begin
        mul_a = SQ_W'(e2_r);
        mul_b = om_r;
      end
      STEP_E2_OMP: begin
        mul_a = SQ_W'(e2_r);
        mul_b = omp_r;
      end
      default: ;
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      case (cnt_r)
        STEP_SQ_OM:  sq_om_r     <= prod[SQ_W-1:0];
        STEP_SQ_E2:  sq_e2_r     <= prod[2*MIS_W-1:0];
        STEP_SQ_OMM: sq_omm_r    <= prod[SQ_W-1:0];
        STEP_E1_OMM: e1_sq_omm_r <= prod;
        STEP_E2_OM:  e2_om_r     <= prod[SQ_W-1:0];
        STEP_E2_OMP: e2_omp_r    <= prod[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos3 = (WIDE_W'(sq_om_r) + WIDE_W'(sq_e2_r)) << FRAC_BITS;
    neg3 = WIDE_W'(e1_sq_omm_r) << 1;
    sum4 = WIDE_W'(e1_sq_omm_r) + (WIDE_W'(e2_om_r) << FRAC_BITS);
    tab_c.p_hom_match = sat_prob(WIDE_W'(sq_om_r) >> FRAC_BITS);
    tab_c.p_hom_one   = sat_prob(WIDE_W'(e2_om_r) >> (FRAC_BITS - 1));
    tab_c.p_none_hom  = sat_prob(WIDE_W'(sq_e2_r) >> FRAC_BITS);
    tab_c.p_none_het  = sat_prob(WIDE_W'(sq_e2_r) >> (FRAC_BITS - 1));
    tab_c.p_het_match = (pos3 > neg3) ? sat_prob((pos3 - neg3) >> (2 * FRAC_BITS)) : '0;
    tab_c.p_het_drop  = sat_prob(sum4 >> (2 * FRAC_BITS));
    tab_c.p_het_one   = sat_prob(WIDE_W'(e2_omp_r) >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TABLE) tab_r <= tab_c;
  end

  assign prob_tab     = tab_r;
  assign stat.ready   = (state_r == S_READY);
  assign stat.single  = (allele_r <= COUNT_W'(1));

endmodule

// ===== hdl/gel_front.sv =====
module gel_front import gel_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  cfg_stat_t            stat,
  input  logic                 q_full,
  output logic                 push,
  output item_t                push_item
);

  logic [ALLELE_BITS-1:0] o0, o1, t0, t1;
  logic ohom, m00, m01, m10, m11;
  logic [CASE_W-1:0] mc;

  always_comb begin
    o0  = in_tdata[ALLELE_BITS-1:0];
    o1  = in_tdata[2*ALLELE_BITS-1:ALLELE_BITS];
    t0  = in_tdata[3*ALLELE_BITS-1:2*ALLELE_BITS];
    t1  = in_tdata[4*ALLELE_BITS-1:3*ALLELE_BITS];
    ohom = (o0 == o1);
    m00 = (o0 == t0);
    m01 = (o0 == t1);
    m10 = (o1 == t0);
    m11 = (o1 == t1);
    if (stat.single) begin
      mc = MC_SINGLE;
    end else if (t0 == t1) begin
      if (ohom && m00) mc = MC_HOM_MATCH;
      else if (m00 != m10) mc = MC_HOM_ONE;
      else mc = MC_HOM_NONE;
    end else if ((m00 && m11) || (m10 && m01)) begin
      mc = MC_HET_MATCH;
    end else if (ohom && (m00 || m01)) begin
      mc = MC_HET_DROP;
    end else if (!m00 && !m01 && !m10 && !m11) begin
      mc = MC_HET_NONE;
    end else begin
      mc = MC_HET_ONE;
    end
  end

  assign in_tready       = stat.ready && !q_full;
  assign push            = in_tvalid && in_tready;
  assign push_item.mcase = mc;
  assign push_item.ohom  = ohom;

endmodule

// ===== hdl/gel_queue.sv =====
module gel_queue import gel_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head
);

  item_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_item;
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rd_ptr_r];

endmodule

// ===== hdl/gel_back.sv =====
module gel_back import gel_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  item_t                 head,
  input  prob_table_t           prob_tab,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic              out_valid_r;
  logic [PROB_W-1:0] prob_r, prob_c;
  logic [CASE_W-1:0] case_r;

  always_comb begin
    case (head.mcase)
      MC_HOM_MATCH: prob_c = prob_tab.p_hom_match;
      MC_HOM_ONE:   prob_c = prob_tab.p_hom_one;
      MC_HOM_NONE,
      MC_HET_NONE:  prob_c = head.ohom ? prob_tab.p_none_hom : prob_tab.p_none_het;
      MC_HET_MATCH: prob_c = prob_tab.p_het_match;
      MC_HET_DROP:  prob_c = prob_tab.p_het_drop;
      MC_HET_ONE:   prob_c = prob_tab.p_het_one;
      default:      prob_c = PROB_ONE;
    endcase
  end

  assign pop = head_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prob_r <= prob_c;
      case_r <= head.mcase;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, case_r, prob_r};

endmodule

// ===== hdl/genotyping_error_likelihood_core.sv =====
// Requests pass a two-entry queue and a registered output, one per cycle unless the
// output stalls; the back end reads a per-locus probability table. After reset and
// after every locus register write the input stalls while one 16-step divider and a
// shared 34x17 multiplier (six products) rebuild that table.
// Reset is synchronous and active low; it restores the default locus registers.
module genotyping_error_likelihood_core import gel_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // observed_first, observed_second, true_first, true_second
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // probability, match_case, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cfg_stat_t   stat;
  prob_table_t prob_tab;
  logic        q_full, push, pop, head_valid;
  item_t       push_item, head;

  gel_param u_param (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .prob_tab  (prob_tab)
  );

  gel_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  gel_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  gel_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .prob_tab   (prob_tab),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/gel_likelihood_checker.sv =====
`timescale 1ns / 1ps

module gel_likelihood_checker import gel_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [CASE_W-1:0] mcase;
  } obs_result_t;

  logic [COUNT_W-1:0] allele_cnt  = RST_ALLELE;
  logic [DROP_W-1:0]  drop_rate   = RST_DROPOUT;
  logic [MIS_W-1:0]   mis_rate    = RST_MISTYPE;
  obs_result_t        expected_obs[$];
  int                 fails       = 0;
  int                 queued      = 0;

  assign fail_count = fails;
  assign pending    = queued;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fails++;
  endtask

  // Probability of the observed pair given the true pair, under the current locus registers.
  function automatic obs_result_t predict_observation(input logic [IN_DATA_W-1:0] d);
    logic [ALLELE_BITS-1:0] o0, o1, t0, t1;
    longint unsigned one, e1, em, e2, om, omm, omp, s, q, pos, neg;
    bit om_neg, omp_neg, ohom;
    logic [CASE_W-1:0] mc;
    obs_result_t r;
    o0 = d[0 +: ALLELE_BITS];
    o1 = d[ALLELE_BITS +: ALLELE_BITS];
    t0 = d[2*ALLELE_BITS +: ALLELE_BITS];
    t1 = d[3*ALLELE_BITS +: ALLELE_BITS];
    one = 64'd1 << FRAC_BITS;
    if (allele_cnt <= 1) begin
      r.prob  = PROB_ONE;
      r.mcase = MC_SINGLE;
      return r;
    end
    e1 = drop_rate;
    em = mis_rate;
    e2 = em / (longint'(allele_cnt) - 64'd1);
    om_neg  = em > one;
    om      = om_neg ? em - one : one - em;
    s       = em + e2;
    omm     = s > one ? s - one : one - s;
    omp_neg = em > one + e2;
    omp     = omp_neg ? em - (one + e2) : one + e2 - em;
    ohom    = (o0 == o1);

    if (t0 == t1) begin
      if (ohom && o0 == t0) mc = MC_HOM_MATCH;
      else if ((o0 == t0) != (o1 == t0)) mc = MC_HOM_ONE;
      else mc = MC_HOM_NONE;
    end else if ((o0 == t0 && o1 == t1) || (o1 == t0 && o0 == t1)) begin
      mc = MC_HET_MATCH;
    end else if (ohom && (o0 == t0 || o0 == t1)) begin
      mc = MC_HET_DROP;
    end else if (o0 != t0 && o0 != t1 && o1 != t0 && o1 != t1) begin
      mc = MC_HET_NONE;
    end else begin
      mc = MC_HET_ONE;
    end

    case (mc)
      MC_HOM_MATCH: begin
        q = (om * om) >> FRAC_BITS;
      end
      MC_HOM_ONE: begin
        q = om_neg ? 64'd0 : ((64'd2 * e2 * om) >> FRAC_BITS);
      end
      MC_HOM_NONE, MC_HET_NONE: begin
        q = ((ohom ? 64'd1 : 64'd2) * e2 * e2) >> FRAC_BITS;
      end
      MC_HET_MATCH: begin
        pos = (om * om + e2 * e2) << FRAC_BITS;
        neg = 64'd2 * e1 * omm * omm;
        q = pos > neg ? ((pos - neg) >> (2 * FRAC_BITS)) : 64'd0;
      end
      MC_HET_DROP: begin
        pos = e1 * omm * omm;
        neg = (e2 * om) << FRAC_BITS;
        if (om_neg) q = pos > neg ? ((pos - neg) >> (2 * FRAC_BITS)) : 64'd0;
        else q = (pos + neg) >> (2 * FRAC_BITS);
      end
      default: begin
        q = omp_neg ? 64'd0 : ((e2 * omp) >> FRAC_BITS);
      end
    endcase

    if (q > one) q = one;
    r.prob  = q[PROB_W-1:0];
    r.mcase = mc;
    return r;
  endfunction

  always @(posedge clk) begin
    obs_result_t       want;
    logic [PROB_W-1:0] got_prob;
    logic [CASE_W-1:0] got_case;
    if (!rst_n) begin
      allele_cnt = RST_ALLELE;
      drop_rate  = RST_DROPOUT;
      mis_rate   = RST_MISTYPE;
      expected_obs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALLELE:  allele_cnt = cfg_data[COUNT_W-1:0];
          REG_DROPOUT: drop_rate  = cfg_data[DROP_W-1:0];
          REG_MISTYPE: mis_rate   = cfg_data[MIS_W-1:0];
          default: ;
        endcase
      end
      // The result leaving now belongs to an earlier request, so it is matched first.
      if (out_tvalid && out_tready) begin
        got_prob = out_tdata[PROB_W-1:0];
        got_case = out_tdata[PROB_W +: CASE_W];
        if (expected_obs.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding (prob %0d case %0d)",
                                    got_prob, got_case));
        end else begin
          want = expected_obs.pop_front();
          if (got_prob !== want.prob)
            report_mismatch($sformatf("probability expected %0d, got %0d (case %0d)",
                                      want.prob, got_prob, want.mcase));
          if (got_case !== want.mcase)
            report_mismatch($sformatf("match case expected %0d, got %0d",
                                      want.mcase, got_case));
        end
      end
      if (in_tvalid && in_tready)
        expected_obs.insert(expected_obs.size(), predict_observation(in_tdata));
    end
    queued <= expected_obs.size();
  end

endmodule

// ===== tb/sv/genotyping_error_likelihood_core_test.sv =====
`timescale 1ns / 1ps

module genotyping_error_likelihood_core_test;
  import gel_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES     = 10;
  localparam int PHASE_REQS = 92;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    pending;
  bit                    idle_on = 1'b1;
  int                    ready_hold = 0;

  genotyping_error_likelihood_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gel_likelihood_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_alleles(
    input logic [ALLELE_BITS-1:0] o0, o1, t0, t1);
    return {t1, t0, o1, o0};
  endfunction

  // Builds a request that lands in the given match case, with random allele codes.
  function automatic logic [IN_DATA_W-1:0] make_case_req(input int mc);
    logic [ALLELE_BITS-1:0] a, b, c, d;
    bit flip;
    a = ALLELE_BITS'($urandom_range(0, 255));
    do b = ALLELE_BITS'($urandom_range(0, 255)); while (b == a);
    do c = ALLELE_BITS'($urandom_range(0, 255)); while (c == a || c == b);
    do d = ALLELE_BITS'($urandom_range(0, 255)); while (d == a || d == b || d == c);
    flip = 1'($urandom_range(0, 1));
    case (mc)
      MC_HOM_MATCH: return pack_alleles(a, a, a, a);
      MC_HOM_ONE:   return flip ? pack_alleles(c, a, a, a) : pack_alleles(a, c, a, a);
      MC_HOM_NONE:  return flip ? pack_alleles(c, c, a, a) : pack_alleles(c, d, a, a);
      MC_HET_MATCH: return flip ? pack_alleles(b, a, a, b) : pack_alleles(a, b, a, b);
      MC_HET_DROP:  return flip ? pack_alleles(b, b, a, b) : pack_alleles(a, a, a, b);
      MC_HET_NONE:  return flip ? pack_alleles(c, c, a, b) : pack_alleles(c, d, a, b);
      default: begin
        case ($urandom_range(0, 3))
          0: return pack_alleles(a, c, a, b);
          1: return pack_alleles(c, a, a, b);
          2: return pack_alleles(b, c, a, b);
          default: return pack_alleles(c, b, a, b);
        endcase
      end
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_random_req();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return make_case_req($urandom_range(0, 6));
  endfunction

  task automatic send_req(input logic [IN_DATA_W-1:0] d);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes the three locus registers in random order once the block has gone quiet.
  task automatic program_locus(input logic [CFG_DATA_W-1:0] acnt, drop, mis,
                               input bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    logic [CFG_IDX_W-1:0]  ti;
    logic [CFG_DATA_W-1:0] tv;
    int j;
    drain_results();
    repeat (3) @(posedge clk);
    idx = '{REG_ALLELE, REG_DROPOUT, REG_MISTYPE};
    val = '{acnt, drop, mis};
    for (int k = 2; k > 0; k--) begin
      j = $urandom_range(0, k);
      ti = idx[k]; idx[k] = idx[j]; idx[j] = ti;
      tv = val[k]; val[k] = val[j]; val[j] = tv;
    end
    for (int k = 0; k < 3; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
    end
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_allele_count();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'd1;
      1: v = 16'd0;
      2: v = 16'd2;
      3: v = 16'd3;
      4: v = 16'd256;
      5: v = 16'd511;
      default: v = CFG_DATA_W'($urandom_range(2, 256));
    endcase
    // Bits above the register width must be dropped by the block.
    v[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W - COUNT_W)'($urandom);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dropout();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'h7fff;
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_mistype();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 16'hffff;
      2: return CFG_DATA_W'($urandom_range(60000, 65535));
      3: return CFG_DATA_W'($urandom_range(0, 8000));
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    out_tready <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset locus: two alleles, both rates near 0.05.
    send_req(pack_alleles(8'd0, 8'd0, 8'd0, 8'd0));
    send_req(pack_alleles(8'd255, 8'd255, 8'd255, 8'd255));
    send_req(pack_alleles(8'd0, 8'd255, 8'd0, 8'd255));
    send_req(pack_alleles(8'd255, 8'd0, 8'd0, 8'd255));
    send_req(pack_alleles(8'd0, 8'd0, 8'd0, 8'd255));
    send_req(pack_alleles(8'd255, 8'd255, 8'd0, 8'd0));
    send_req(pack_alleles(8'd0, 8'd1, 8'd0, 8'd0));
    send_req(pack_alleles(8'd1, 8'd2, 8'd0, 8'd3));
    send_req(pack_alleles(8'd0, 8'd2, 8'd0, 8'd1));
    send_req(pack_alleles(8'd1, 8'd2, 8'd3, 8'd3));
    send_req(pack_alleles(8'd5, 8'd5, 8'd3, 8'd4));

    // Single-allele locus, then a zero allele count which must behave the same.
    program_locus(16'd1, 16'd100, 16'd100, 1'b0);
    send_req(pack_alleles(8'd0, 8'd0, 8'd0, 8'd0));
    send_req(pack_alleles(8'd9, 8'd200, 8'd17, 8'd33));
    program_locus(16'd0, 16'd0, 16'd0, 1'b1);
    send_req(pack_alleles(8'd1, 8'd2, 8'd3, 8'd4));

    // A 256-allele locus with both rates at their register maximum.
    program_locus(16'd256, 16'h7fff, 16'hffff, 1'b1);
    for (int mc = 0; mc < 7; mc++) send_req(make_case_req(mc));

    for (int p = 0; p < PHASES; p++) begin
      program_locus(pick_allele_count(), pick_dropout(), pick_mistype(),
                    $urandom_range(0, 2) == 0);
      idle_on = (p % 4 != 1);
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (i == PHASE_REQS / 2) drain_results();
        send_req(make_random_req());
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gel_pkg.sv
hdl/gel_param.sv
hdl/gel_front.sv
hdl/gel_queue.sv
hdl/gel_back.sv
hdl/genotyping_error_likelihood_core.sv
tb/sv/gel_likelihood_checker.sv
tb/sv/genotyping_error_likelihood_core_test.sv
